// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top level of the marker scanner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define FMS_ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled while reset is asserted.
`define FMS_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed: next-cycle implication");
`else
`define FMS_ASSERT_IMPL(label, clk, rst_n, a, b)
`define FMS_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ----- rtl/fms_pkg.sv -----
// Types and constants of the firmware marker scanner.
package fms_pkg;

    localparam int unsigned WIN_LEN    = 12;
    localparam int unsigned PREFIX_LEN = 8;
    localparam int unsigned FILL_W     = 4;
    localparam int unsigned PREFIX_W   = 64;
    localparam logic [7:0]  END_CHAR   = 8'h40;

    localparam int unsigned APB_ADDR_W  = 4;
    localparam int unsigned APB_DATA_W  = 64;
    localparam int unsigned REG_IDX_LSB = 3;

    typedef enum logic [0:0] {
        REG_MARKER_PREFIX = 1'b0,
        REG_UNUSED        = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic       restart;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic        found;
        logic [7:0]  device_type;
        logic [7:0]  ver_major;
        logic [7:0]  ver_minor;
        logic [7:0]  ver_patch;
        logic [23:0] version_key;
    } out_item_t;

    typedef struct packed {
        logic seen;
        logic full;
    } scan_status_t;

endpackage

// ----- rtl/fms_scan_core.sv -----
// Byte window, prefix compare and capture state of the marker scanner.
module fms_scan_core (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  fms_pkg::in_item_t       item,
    input  logic [63:0]             prefix,
    output fms_pkg::out_item_t      result,
    output fms_pkg::scan_status_t   status
);
    import fms_pkg::*;

    logic [7:0]        win_reg [0:WIN_LEN-1];
    logic [FILL_W-1:0] fill_reg;
    logic              seen_reg;
    logic [31:0]       cap_reg;

    logic [FILL_W-1:0] fill_eff;
    logic              seen_eff;
    logic [31:0]       cap_eff;
    logic              full_eff;
    logic              prefix_hit;
    logic              hit;
    logic              shift;
    logic [FILL_W-1:0] fill_next;
    logic              seen_next;
    logic [31:0]       cap_next;

    // A restart item clears the scan before its own byte is taken in.
    always_comb begin
        fill_eff   = item.restart ? '0 : fill_reg;
        seen_eff   = item.restart ? 1'b0 : seen_reg;
        cap_eff    = item.restart ? '0 : cap_reg;
        full_eff   = (fill_eff == FILL_W'(WIN_LEN));
        prefix_hit = 1'b1;
        for (int k = 0; k < PREFIX_LEN; k++) begin
            if (win_reg[k] != prefix[8*k +: 8]) begin
                prefix_hit = 1'b0;
            end
        end
        hit       = !seen_eff && full_eff && (item.data_byte == END_CHAR) && prefix_hit;
        shift     = !seen_eff && !hit;
        seen_next = seen_eff || hit;
        cap_next  = hit ? {win_reg[8], win_reg[9], win_reg[10], win_reg[11]} : cap_eff;
        if (shift && !full_eff) begin
            fill_next = fill_eff + FILL_W'(1);
        end else begin
            fill_next = fill_eff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            seen_reg <= 1'b0;
            cap_reg  <= '0;
        end else if (en) begin
            fill_reg <= fill_next;
            seen_reg <= seen_next;
            cap_reg  <= cap_next;
        end
    end

    // Newest byte enters at the top; once full, entry 0 holds the oldest byte.
    always_ff @(posedge aclk) begin
        if (en && shift) begin
            for (int i = 0; i < WIN_LEN - 1; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[WIN_LEN-1] <= item.data_byte;
        end
    end

    always_comb begin
        result.found       = seen_next;
        result.device_type = seen_next ? cap_next[31:24] : '0;
        result.ver_major   = seen_next ? cap_next[23:16] : '0;
        result.ver_minor   = seen_next ? cap_next[15:8]  : '0;
        result.ver_patch   = seen_next ? cap_next[7:0]   : '0;
        result.version_key = seen_next ? cap_next[23:0]  : '0;
    end

    assign status.seen = seen_reg;
    assign status.full = (fill_reg == FILL_W'(WIN_LEN));

endmodule

// ----- rtl/firmware_marker_scanner.sv -----
// Top level of the firmware marker scanner: handshakes, APB register and result register.
// An accepted byte is held in the input register; its result is loaded into the output
// register that drives m_payload once that register is empty or being drained.
// Throughput: one byte transaction per cycle unless m_ready stalls, set by the window shift
// and the parallel eight-byte prefix compare between the input and result registers.
// Reset (aresetn low, synchronous) clears the marker prefix, the fill count, the
// found flag, the captured bytes and both valid flags; window contents stay undefined.
`include "assert_macros.svh"
module firmware_marker_scanner (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Byte stream in.
    input  logic                                s_valid,
    output logic                                s_ready,
    input  fms_pkg::in_item_t                   s_payload,
    // Scan results out.
    output logic                                m_valid,
    input  logic                                m_ready,
    output fms_pkg::out_item_t                  m_payload,
    // APB configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fms_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [fms_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [fms_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import fms_pkg::*;

    logic [PREFIX_W-1:0] prefix_reg;
    in_item_t            in_item_reg;
    logic                in_valid_reg;
    out_item_t           out_item_reg;
    logic                out_valid_reg;

    logic                advance;
    logic                proc;
    reg_idx_t            reg_idx;
    out_item_t           core_result;
    scan_status_t        core_status;
    logic                seen_keep;
    logic                unfound_zero;

    // Register file. The APB port never stalls, so a write lands on the access cycle.
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[REG_IDX_LSB]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_reg <= '0;
        end else if (psel && penable && pwrite && (reg_idx == REG_MARKER_PREFIX)) begin
            prefix_reg <= pwdata;
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MARKER_PREFIX: prdata = prefix_reg;
            REG_UNUSED:        prdata = '0;
            default:           prdata = '0;
        endcase
    end

    // Two-register pipeline. The input register holds an accepted byte transaction;
    // it is scanned and its result loaded into the output register whenever that
    // register is empty or being drained. A new byte is therefore taken in the
    // same cycle a waiting result leaves: one transaction per cycle unless m_ready stalls.
    assign advance = !out_valid_reg || m_ready;
    assign proc    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_payload;
        end
        if (proc) begin
            out_item_reg <= core_result;
        end
    end

    // The core updates its scan state only when the held byte is actually consumed,
    // so a stalled result never causes a byte to be scanned twice.
    fms_scan_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (proc),
        .item    (in_item_reg),
        .prefix  (prefix_reg),
        .result  (core_result),
        .status  (core_status)
    );

    assign m_valid   = out_valid_reg;
    assign m_payload = out_item_reg;

    // Conditions used by the checks below.
    assign seen_keep    = core_status.seen && !(proc && in_item_reg.restart);
    assign unfound_zero = (out_item_reg.device_type == 8'h00) &&
                          (out_item_reg.version_key == 24'h000000);

    // A marker can only have been seen with a full window, and the window stops
    // changing afterwards, so the full indication must hold while found is set.
    `FMS_ASSERT_IMPL(a_seen_full, aclk, aresetn, core_status.seen, core_status.full)
    // The found flag is sticky until a restart transaction is consumed.
    `FMS_ASSERT_NEXT(a_seen_sticky, aclk, aresetn, seen_keep, core_status.seen)
    // A result without a found marker carries all-zero captured fields.
    `FMS_ASSERT_IMPL(a_zero_unfound, aclk, aresetn, out_valid_reg && !out_item_reg.found, unfound_zero)
    // A byte held in the input register that cannot move on is still held next cycle.
    `FMS_ASSERT_NEXT(a_in_hold, aclk, aresetn, in_valid_reg && !advance, in_valid_reg && $stable(in_item_reg))

endmodule
